// File: rtl/lkc_pkg.sv
package lkc_pkg;

	localparam int KEY_BYTES    = 5;
	localparam int KEY_W        = 8 * KEY_BYTES;
	localparam int CNT_W        = 16;
	localparam int CAPACITY_DEF = 16;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef enum logic [1:0] {
		CMD_PRELOAD = 2'd0,
		CMD_ACCESS  = 2'd1,
		CMD_DUMP    = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		STS_MISS_INS   = 3'd0,
		STS_HIT        = 3'd1,
		STS_MISS_EVICT = 3'd2,
		STS_PRELOADED  = 3'd3,
		STS_DROPPED    = 3'd4,
		STS_DUMP       = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_WAIT,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic             en;
		logic [KEY_W-1:0] key;
		logic [CNT_W-1:0] uses;
	} wr_req_t;

	typedef struct packed {
		logic clr;
		logic smp;
		logic elig;
	} scan_ctl_t;

	typedef struct packed {
		logic             match_found;
		logic [CNT_W-1:0] match_uses;
		logic             min_found;
		logic [KEY_W-1:0] min_key;
		logic [CNT_W-1:0] min_uses;
	} scan_res_t;

endpackage

// File: rtl/lkc_store.sv
module lkc_store #(
	parameter int CAPACITY = lkc_pkg::CAPACITY_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [$clog2(CAPACITY)-1:0]   rd_addr,
	input  lkc_pkg::wr_req_t              wr,
	input  logic [$clog2(CAPACITY)-1:0]   wr_addr,
	output logic [lkc_pkg::KEY_W-1:0]     rd_key,
	output logic [lkc_pkg::CNT_W-1:0]     rd_uses,
	output logic [CAPACITY-1:0]           valid
);
	import lkc_pkg::*;

	logic [KEY_W+CNT_W-1:0] mem [CAPACITY];
	logic [KEY_W+CNT_W-1:0] rd_data_q;
	logic [CAPACITY-1:0]    valid_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr_addr] <= {wr.key, wr.uses};
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Entries are never removed, only overwritten, so a valid bit once set stays set.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	assign rd_key  = rd_data_q[KEY_W+CNT_W-1:CNT_W];
	assign rd_uses = rd_data_q[CNT_W-1:0];
	assign valid   = valid_q;

	a_valid_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ((valid_q & $past(valid_q)) == $past(valid_q)))
		else $error("slot valid bit cleared");

endmodule

// File: rtl/lkc_scan.sv
module lkc_scan #(
	parameter int CAPACITY = lkc_pkg::CAPACITY_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lkc_pkg::scan_ctl_t            ctl,
	input  logic [$clog2(CAPACITY)-1:0]   idx,
	input  logic [lkc_pkg::KEY_W-1:0]     cand_key,
	input  logic [lkc_pkg::CNT_W-1:0]     cand_uses,
	input  logic [lkc_pkg::KEY_W-1:0]     search_key,
	output lkc_pkg::scan_res_t            res,
	output logic [$clog2(CAPACITY)-1:0]   match_idx,
	output logic [$clog2(CAPACITY)-1:0]   min_idx
);
	import lkc_pkg::*;

	localparam int IDX_W = $clog2(CAPACITY);

	logic             match_found_q;
	logic             min_found_q;
	logic [CNT_W-1:0] match_uses_q;
	logic [KEY_W-1:0] min_key_q;
	logic [CNT_W-1:0] min_uses_q;
	logic [IDX_W-1:0] match_idx_q;
	logic [IDX_W-1:0] min_idx_q;
	logic             is_match;
	logic             better;

	assign is_match = ctl.smp && ctl.elig && (cand_key == search_key);

	// Rank order: lower use count first, then the smaller key.
	assign better = ctl.smp && ctl.elig && (!min_found_q || (cand_uses < min_uses_q) ||
		((cand_uses == min_uses_q) && (cand_key < min_key_q)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_found_q <= 1'b0;
			min_found_q   <= 1'b0;
		end else if (ctl.clr) begin
			match_found_q <= 1'b0;
			min_found_q   <= 1'b0;
		end else begin
			if (is_match) begin
				match_found_q <= 1'b1;
			end
			if (better) begin
				min_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (is_match) begin
			match_uses_q <= cand_uses;
			match_idx_q  <= idx;
		end
		if (better) begin
			min_key_q  <= cand_key;
			min_uses_q <= cand_uses;
			min_idx_q  <= idx;
		end
	end

	assign res.match_found = match_found_q;
	assign res.match_uses  = match_uses_q;
	assign res.min_found   = min_found_q;
	assign res.min_key     = min_key_q;
	assign res.min_uses    = min_uses_q;
	assign match_idx       = match_idx_q;
	assign min_idx         = min_idx_q;

	a_min_only_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(min_found_q) |-> $past(ctl.clr))
		else $error("minimum search lost its candidate without a restart");

endmodule

// File: rtl/lfu_key_cache_unit.sv
// Least-frequently-used table of short keys, held in a one-port-read, one-port-write
// memory of CAPACITY entries with a flop per entry for its valid bit.
// Input channel (in_valid/in_ready) takes one command beat: preload, access or dump.
// in_ready is high only while the block is idle; one command is worked at a time.
// Output channel (out_valid/out_ready) returns result beats; last marks the final
// beat of a command. A single output register parts the channels, so the next
// command is taken while a result still waits there.
// Preload and access sweep every slot once, one slot per cycle through the memory
// read port, then write back; the result beat is registered with that write, and
// the block turns idle as the beat becomes valid, so the next command can be taken
// while it waits. A full output register holds the block before the write.
// A dump sweeps the memory once per listed entry; each new sweep starts as the
// previous beat is written to the output register. Beats come in ascending count
// and then ascending key.
// An unknown command skips the sweep and gives a single dropped beat.
// Reset clears all valid bits at once and leaves the block idle, so a command can be
// taken as soon as reset is released; memory needs no clearing.
// When the receiver stalls, the finished beat holds in the output register and
// the block waits before writing its next result.
module lfu_key_cache_unit #(
	parameter int CAPACITY = lkc_pkg::CAPACITY_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [1:0]                command,
	input  logic [lkc_pkg::KEY_W-1:0] key,
	input  logic [lkc_pkg::CNT_W-1:0] preload_count,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [2:0]                status,
	output logic [lkc_pkg::KEY_W-1:0] result_key,
	output logic [lkc_pkg::CNT_W-1:0] result_count,
	output logic                      entry_present,
	output logic                      last
);
	import lkc_pkg::*;

	localparam int               IDX_W    = $clog2(CAPACITY);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

	state_t              state_q, state_d;
	cmd_t                cmd_q;
	logic [KEY_W-1:0]    key_q;
	logic [CNT_W-1:0]    pcnt_q;
	logic [IDX_W-1:0]    rd_idx_q;
	logic                smp_vld_s1;
	logic [IDX_W-1:0]    smp_idx_s1;
	logic [CAPACITY-1:0] taken_q;

	logic                out_vld_q;
	status_t             out_status_q;
	logic [KEY_W-1:0]    out_key_q;
	logic [CNT_W-1:0]    out_cnt_q;
	logic                out_present_q;
	logic                out_last_q;

	logic [CAPACITY-1:0] slot_valid;
	logic [KEY_W-1:0]    rd_key;
	logic [CNT_W-1:0]    rd_uses;
	logic                rd_en;
	wr_req_t             wr;
	logic [IDX_W-1:0]    wr_addr;
	scan_ctl_t           scan_ctl;
	scan_res_t           scan_res;
	logic [IDX_W-1:0]    match_idx;
	logic [IDX_W-1:0]    min_idx;

	logic                clr;
	logic                take;
	logic                emit;
	status_t             em_status;
	logic [KEY_W-1:0]    em_key;
	logic [CNT_W-1:0]    em_cnt;
	logic                em_present;
	logic                em_last;
	logic                out_free;
	logic                full;
	logic [IDX_W-1:0]    free_idx;
	logic [CAPACITY-1:0] remaining;
	logic [CNT_W-1:0]    hit_uses;

	lkc_store #(.CAPACITY(CAPACITY)) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_idx_q),
		.wr      (wr),
		.wr_addr (wr_addr),
		.rd_key  (rd_key),
		.rd_uses (rd_uses),
		.valid   (slot_valid)
	);

	lkc_scan #(.CAPACITY(CAPACITY)) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (scan_ctl),
		.idx        (smp_idx_s1),
		.cand_key   (rd_key),
		.cand_uses  (rd_uses),
		.search_key (key_q),
		.res        (scan_res),
		.match_idx  (match_idx),
		.min_idx    (min_idx)
	);

	assign in_ready = (state_q == S_IDLE);
	assign out_free = !out_vld_q || out_ready;
	assign rd_en    = (state_q == S_SCAN);
	assign full     = &slot_valid;

	assign scan_ctl.clr  = clr;
	assign scan_ctl.smp  = smp_vld_s1;
	assign scan_ctl.elig = slot_valid[smp_idx_s1] && !taken_q[smp_idx_s1];

	// Slots still to be listed once the present minimum has been emitted.
	assign remaining = slot_valid & ~taken_q & ~(CAPACITY'(1) << min_idx);

	assign hit_uses = (scan_res.match_uses == CNT_MAX) ? CNT_MAX :
		scan_res.match_uses + CNT_W'(1);

	always_comb begin
		free_idx = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (!slot_valid[i]) begin
				free_idx = IDX_W'(i);
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		clr        = 1'b0;
		take       = 1'b0;
		wr         = '0;
		wr_addr    = free_idx;
		emit       = 1'b0;
		em_status  = STS_DROPPED;
		em_key     = '0;
		em_cnt     = '0;
		em_present = 1'b0;
		em_last    = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					clr     = 1'b1;
					state_d = (cmd_t'(command) == CMD_NONE) ? S_FINISH : S_SCAN;
				end
			end
			S_SCAN: begin
				if (rd_idx_q == LAST_IDX) begin
					state_d = S_WAIT;
				end
			end
			S_WAIT: begin
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (out_free) begin
					emit    = 1'b1;
					state_d = S_IDLE;
					unique case (cmd_q)
						CMD_PRELOAD: begin
							if (!scan_res.match_found && !full) begin
								wr.en     = 1'b1;
								wr.key    = key_q;
								wr.uses   = pcnt_q;
								em_status = STS_PRELOADED;
								em_cnt    = pcnt_q;
							end
						end
						CMD_ACCESS: begin
							wr.en  = 1'b1;
							wr.key = key_q;
							if (scan_res.match_found) begin
								wr_addr   = match_idx;
								wr.uses   = hit_uses;
								em_status = STS_HIT;
								em_cnt    = hit_uses;
							end else if (!full) begin
								wr.uses   = CNT_W'(1);
								em_status = STS_MISS_INS;
								em_cnt    = CNT_W'(1);
							end else begin
								wr_addr   = min_idx;
								wr.uses   = CNT_W'(1);
								em_status = STS_MISS_EVICT;
								em_key    = scan_res.min_key;
								em_cnt    = CNT_W'(1);
							end
						end
						CMD_DUMP: begin
							em_status = STS_DUMP;
							if (scan_res.min_found) begin
								em_key     = scan_res.min_key;
								em_cnt     = scan_res.min_uses;
								em_present = 1'b1;
								em_last    = (remaining == '0);
								take       = 1'b1;
								if (remaining != '0) begin
									clr     = 1'b1;
									state_d = S_SCAN;
								end
							end
						end
						CMD_NONE: begin
						end
					endcase
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			smp_vld_s1 <= 1'b0;
			taken_q    <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			state_q    <= state_d;
			smp_vld_s1 <= rd_en;
			if (state_q == S_IDLE) begin
				taken_q <= '0;
			end else if (take) begin
				taken_q[min_idx] <= 1'b1;
			end
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		smp_idx_s1 <= rd_idx_q;
		if (clr) begin
			rd_idx_q <= '0;
		end else if (rd_en) begin
			rd_idx_q <= rd_idx_q + IDX_W'(1);
		end
		if (in_valid && in_ready) begin
			cmd_q  <= cmd_t'(command);
			key_q  <= key;
			pcnt_q <= preload_count;
		end
		if (emit) begin
			out_status_q  <= em_status;
			out_key_q     <= em_key;
			out_cnt_q     <= em_cnt;
			out_present_q <= em_present;
			out_last_q    <= em_last;
		end
	end

	assign out_valid     = out_vld_q;
	assign status        = out_status_q;
	assign result_key    = out_key_q;
	assign result_count  = out_cnt_q;
	assign entry_present = out_present_q;
	assign last          = out_last_q;

	a_victim_exists: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH && cmd_q == CMD_ACCESS && !scan_res.match_found && full)
		|-> scan_res.min_found)
		else $error("full table without an eviction candidate");

	a_access_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH && out_free && cmd_q == CMD_ACCESS) |=> (slot_valid != '0))
		else $error("table empty after an access");

	a_dump_entry_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && cmd_q == CMD_DUMP && scan_res.min_found)
		|-> (slot_valid[min_idx] && !taken_q[min_idx]))
		else $error("dump listed an invalid or already listed slot");

endmodule
